// ----- rtl/trffp_pkg.sv -----
// ============================================================================
// trffp_pkg - shared types and codes of the two-resource first-fit placer
// Field widths, operation and status codes, and the request, result and
// usage word layouts used by the controller and the top level.
// ============================================================================
package trffp_pkg;

   // default table depth
   localparam int unsigned MAX_SERVERS_DEF = 64;

   // field widths
   localparam int OP_W     = 2;
   localparam int IDX_W    = 6;
   localparam int MEM_W    = 8;
   localparam int CPU_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // stream widths
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ONLY_GUEST = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd3;

   // one accepted request
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] dst;
      logic [MEM_W-1:0] mem;
      logic [CPU_W-1:0] cpu;
   } req_type;

   // one result
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    loc;
      logic [COUNT_W-1:0]  busy;
   } res_type;

   // memory and CPU pair, used for both capacity and usage words
   typedef struct packed {
      logic [MEM_W-1:0] mem;
      logic [CPU_W-1:0] cpu;
   } usage_type;

endpackage

// ----- rtl/trffp_ram.sv -----
// ============================================================================
// trffp_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
module trffp_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/trffp_ctrl.sv -----
// ============================================================================
// trffp_ctrl - sequencer of the placer around the capacity and usage RAMs
// Clears usage after reset, then runs load, first-fit scan and move as
// read-modify-write sequences on the two memories, one request at a time.
// ============================================================================
module trffp_ctrl #(
   parameter int unsigned MAX_SERVERS = trffp_pkg::MAX_SERVERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_accept,
   input  trffp_pkg::req_type                req,
   input  logic [trffp_pkg::COUNT_W-1:0]     server_count,
   input  logic                              slot_free,
   output logic                              req_ready,
   output logic                              res_valid,
   output trffp_pkg::res_type                res
);
   import trffp_pkg::*;

   localparam int AW     = $clog2(MAX_SERVERS);
   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int WORD_W = $bits(usage_type);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_MV_SRC,
      S_MV_DST,
      S_MV_SUB,
      S_RESP
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [AW-1:0]         chk_idx_ff, chk_idx_in;
   usage_type             src_use_ff, src_use_in;
   logic [CNT_W-1:0]      busy_ff, busy_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [IDX_W-1:0]      loc_ff, loc_in;

   // memory ports
   logic                  use_we, use_re, cap_we, cap_re;
   logic [AW-1:0]         use_waddr, use_raddr, cap_waddr, cap_raddr;
   usage_type             use_wdata, cap_wdata, use_rd, cap_rd;
   logic [WORD_W-1:0]     use_rd_raw, cap_rd_raw;

   // derived values
   logic [WIDE_W-1:0]     n_wide, max_wide, sc_wide;
   logic [WIDE_W-1:0]     src_new_wide, dst_wide, scan_wide;
   logic                  room;
   usage_type             add_use, sub_use;

   function automatic logic fits(usage_type used, usage_type cap,
                                 logic [MEM_W-1:0] m, logic [CPU_W-1:0] c);
      logic [MEM_W:0] sum_mem;
      logic [CPU_W:0] sum_cpu;
      sum_mem = {1'b0, used.mem} + {1'b0, m};
      sum_cpu = {1'b0, used.cpu} + {1'b0, c};
      return (sum_mem <= {1'b0, cap.mem}) && (sum_cpu <= {1'b0, cap.cpu});
   endfunction

   trffp_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SERVERS)) u_use_ram (
      .clock   (clock),
      .wr_en   (use_we),
      .wr_addr (use_waddr),
      .wr_data (use_wdata),
      .rd_en   (use_re),
      .rd_addr (use_raddr),
      .rd_data (use_rd_raw)
   );

   trffp_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SERVERS)) u_cap_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (cap_waddr),
      .wr_data (cap_wdata),
      .rd_en   (cap_re),
      .rd_addr (cap_raddr),
      .rd_data (cap_rd_raw)
   );

   assign use_rd = use_rd_raw;
   assign cap_rd = cap_rd_raw;

   // effective server count and index compares
   assign sc_wide      = WIDE_W'(server_count);
   assign max_wide     = WIDE_W'(MAX_SERVERS);
   assign n_wide       = (sc_wide > max_wide) ? max_wide : sc_wide;
   assign src_new_wide = WIDE_W'(req.src);
   assign dst_wide     = WIDE_W'(req_ff.dst);
   assign scan_wide    = WIDE_W'(scan_ff);

   // room test and updated usage words on the returned read data
   assign room        = fits(use_rd, cap_rd, req_ff.mem, req_ff.cpu);
   assign add_use.mem = use_rd.mem + req_ff.mem;
   assign add_use.cpu = use_rd.cpu + req_ff.cpu;
   assign sub_use.mem = src_use_ff.mem - req_ff.mem;
   assign sub_use.cpu = src_use_ff.cpu - req_ff.cpu;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      scan_in    = scan_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      src_use_in = src_use_ff;
      busy_in    = busy_ff;
      status_in  = status_ff;
      loc_in     = loc_ff;
      use_we     = 1'b0;
      use_waddr  = '0;
      use_wdata  = '0;
      use_re     = 1'b0;
      use_raddr  = '0;
      cap_we     = 1'b0;
      cap_waddr  = '0;
      cap_wdata  = '0;
      cap_re     = 1'b0;
      cap_raddr  = '0;

      unique case (state_ff)
         // zero one usage entry a cycle
         S_CLEAR: begin
            use_we    = 1'b1;
            use_waddr = scan_ff[AW-1:0];
            if (scan_ff == CNT_W'(MAX_SERVERS - 1)) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end

         // take a request and start its first read
         S_IDLE: begin
            if (req_accept) begin
               req_in = req;
               case (req.op)
                  OP_LOAD: begin
                     if (src_new_wide < max_wide) begin
                        use_re    = 1'b1;
                        use_raddr = AW'(req.src);
                        state_in  = S_LOAD;
                     end else begin
                        status_in = ST_INVALID;
                        loc_in    = req.src;
                        state_in  = S_RESP;
                     end
                  end
                  OP_PLACE: begin
                     scan_in    = '0;
                     chk_vld_in = 1'b0;
                     state_in   = S_SCAN;
                  end
                  OP_MOVE: begin
                     if (src_new_wide < n_wide) begin
                        use_re    = 1'b1;
                        use_raddr = AW'(req.src);
                        state_in  = S_MV_SRC;
                     end else begin
                        status_in = ST_INVALID;
                        loc_in    = req.src;
                        state_in  = S_RESP;
                     end
                  end
                  default: begin
                     status_in = ST_INVALID;
                     loc_in    = '0;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end

         // write capacities, drop usage, adjust busy count
         S_LOAD: begin
            cap_we    = 1'b1;
            cap_waddr = AW'(req_ff.src);
            cap_wdata = '{mem: req_ff.mem, cpu: req_ff.cpu};
            use_we    = 1'b1;
            use_waddr = AW'(req_ff.src);
            use_wdata = '0;
            if (use_rd.mem != '0) begin
               busy_in = busy_ff - CNT_W'(1);
            end
            status_in = ST_DONE;
            loc_in    = req_ff.src;
            state_in  = S_RESP;
         end

         // issue one read a cycle, test the entry that returned
         S_SCAN: begin
            if (chk_vld_ff && room) begin
               use_we    = 1'b1;
               use_waddr = chk_idx_ff;
               use_wdata = add_use;
               if (use_rd.mem == '0 && add_use.mem != '0) begin
                  busy_in = busy_ff + CNT_W'(1);
               end
               chk_vld_in = 1'b0;
               status_in  = ST_DONE;
               loc_in     = IDX_W'(chk_idx_ff);
               state_in   = S_RESP;
            end else if (scan_wide < n_wide) begin
               use_re     = 1'b1;
               use_raddr  = scan_ff[AW-1:0];
               cap_re     = 1'b1;
               cap_raddr  = scan_ff[AW-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end else begin
               chk_vld_in = 1'b0;
               status_in  = ST_NO_ROOM;
               loc_in     = '0;
               state_in   = S_RESP;
            end
         end

         // check the source, then fetch the target
         S_MV_SRC: begin
            src_use_in = use_rd;
            loc_in     = req_ff.src;
            if (use_rd.mem < req_ff.mem || use_rd.cpu < req_ff.cpu) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else if (use_rd.mem == req_ff.mem) begin
               status_in = ST_ONLY_GUEST;
               state_in  = S_RESP;
            end else if (dst_wide >= n_wide || req_ff.dst == req_ff.src) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else begin
               use_re    = 1'b1;
               use_raddr = AW'(req_ff.dst);
               cap_re    = 1'b1;
               cap_raddr = AW'(req_ff.dst);
               state_in  = S_MV_DST;
            end
         end

         // add to the target when it has room
         S_MV_DST: begin
            if (!room) begin
               status_in = ST_NO_ROOM;
               loc_in    = req_ff.src;
               state_in  = S_RESP;
            end else begin
               use_we    = 1'b1;
               use_waddr = AW'(req_ff.dst);
               use_wdata = add_use;
               if (use_rd.mem == '0 && add_use.mem != '0) begin
                  busy_in = busy_ff + CNT_W'(1);
               end
               state_in = S_MV_SUB;
            end
         end

         // take the request off the source
         S_MV_SUB: begin
            use_we    = 1'b1;
            use_waddr = AW'(req_ff.src);
            use_wdata = sub_use;
            if (src_use_ff.mem != '0 && sub_use.mem == '0) begin
               busy_in = busy_ff - CNT_W'(1);
            end
            status_in = ST_DONE;
            loc_in    = req_ff.dst;
            state_in  = S_RESP;
         end

         // hand the result over once the output slot is free
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
         busy_ff    <= busy_in;
      end
      req_ff     <= req_in;
      chk_idx_ff <= chk_idx_in;
      src_use_ff <= src_use_in;
      status_ff  <= status_in;
      loc_ff     <= loc_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_RESP);
   assign res.status = status_ff;
   assign res.loc    = loc_ff;
   assign res.busy   = COUNT_W'(busy_ff);

endmodule

// ----- rtl/two_resource_first_fit_placer_core.sv -----
// ============================================================================
// two_resource_first_fit_placer_core - first-fit placer, two resources
// Place scans one usage and capacity entry a cycle over up to n entries
// (n the effective server count). One request is in work at a time, so
// a request holds the block until its result is handed over; a result
// waits in the output register while the next is taken.
// Reset: synchronous; usage is then cleared entry by entry, with
// req_tready low meanwhile. Capacities are undefined until loaded.
// ============================================================================
module two_resource_first_fit_placer_core #(
   parameter int unsigned MAX_SERVERS = trffp_pkg::MAX_SERVERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: server_index[5:0], target_index[11:6], mem_amount[19:12],
   //        cpu_amount[25:20], zero fill [31:26]
   input  logic [trffp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: operation[1:0]
   input  logic [trffp_pkg::OP_W-1:0]           req_tuser,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: status[1:0], location[7:2], servers_in_use[14:8], zero [15]
   output logic [trffp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration: server_count
   input  logic                                 csr_wr_en,
   input  logic [trffp_pkg::COUNT_W-1:0]        csr_wr_data
);
   import trffp_pkg::*;

   logic [COUNT_W-1:0] server_count_ff;
   req_type            req;
   logic               req_accept;
   logic               slot_free;
   logic               res_valid;
   res_type            res;
   logic               rsp_tvalid_ff;
   res_type            rsp_data_ff;

   // unpack the request
   assign req.op  = req_tuser;
   assign req.src = req_tdata[5:0];
   assign req.dst = req_tdata[11:6];
   assign req.mem = req_tdata[19:12];
   assign req.cpu = req_tdata[25:20];

   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   // server count register
   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= COUNT_W'(1);
      end else if (csr_wr_en) begin
         server_count_ff <= csr_wr_data;
      end
   end

   trffp_ctrl #(.MAX_SERVERS(MAX_SERVERS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req          (req),
      .server_count (server_count_ff),
      .slot_free    (slot_free),
      .req_ready    (req_tready),
      .res_valid    (res_valid),
      .res          (res)
   );

   // output register: load on handover, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (res_valid && slot_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (res_valid && slot_free) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.busy, rsp_data_ff.loc, rsp_data_ff.status};

`ifndef SYNTHESIS
   // the clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("request taken during usage clearing");

   // only one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("second request taken while one is in work");

   // a handed-over result shows on the port in the next cycle
   a_handover: assert property (@(posedge clock) disable iff (reset)
      res_valid && slot_free |=> rsp_tvalid && rsp_tdata[7:2] == $past(res.loc))
      else $error("result lost at the output register");
`endif

endmodule
